@@ rtl/rgbycc_pkg.sv @@
// Package for the RGB to YCbCr 4:2:2 pair converter.
// Holds the coefficients, offsets and the types shared by the lane, merge and top modules.
// No dependencies.
package rgbycc_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned COEF_W = 14;
    localparam int unsigned SUM_W  = 16;

    localparam logic signed [COEF_W-1:0] COEF_Y_R  = 14'sd2449;
    localparam logic signed [COEF_W-1:0] COEF_Y_G  = 14'sd4808;
    localparam logic signed [COEF_W-1:0] COEF_Y_B  = 14'sd933;
    localparam logic signed [COEF_W-1:0] COEF_CB_R = -14'sd691;
    localparam logic signed [COEF_W-1:0] COEF_CB_G = -14'sd1356;
    localparam logic signed [COEF_W-1:0] COEF_CB_B = 14'sd2048;
    localparam logic signed [COEF_W-1:0] COEF_CR_R = 14'sd2048;
    localparam logic signed [COEF_W-1:0] COEF_CR_G = -14'sd1714;
    localparam logic signed [COEF_W-1:0] COEF_CR_B = -14'sd333;

    localparam logic [SUM_W-1:0] OFFSET_Y = 16'd16;
    localparam logic [SUM_W-1:0] OFFSET_C = 16'd4112;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [SUM_W-1:0] y_r;
        logic [SUM_W-1:0] y_g;
        logic [SUM_W-1:0] y_b;
        logic [SUM_W-1:0] cb_r;
        logic [SUM_W-1:0] cb_g;
        logic [SUM_W-1:0] cb_b;
        logic [SUM_W-1:0] cr_r;
        logic [SUM_W-1:0] cr_g;
        logic [SUM_W-1:0] cr_b;
    } prod_t;

    typedef struct packed {
        logic [CHAN_W-1:0] luma_first;
        logic [CHAN_W-1:0] luma_second;
        logic [CHAN_W-1:0] chroma_blue;
        logic [CHAN_W-1:0] chroma_red;
        logic              last_out;
    } ycc_t;

endpackage

@@ rtl/rgbycc_in_if.sv @@
// Interface for the RGB pixel pair channel.
// Depends on nothing; carries valid, ready and the pair payload.
interface rgbycc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       last_pair;

    modport source (
        output valid, red_first, green_first, blue_first,
        output red_second, green_second, blue_second, last_pair,
        input  ready
    );

    modport sink (
        input  valid, red_first, green_first, blue_first,
        input  red_second, green_second, blue_second, last_pair,
        output ready
    );
endinterface

@@ rtl/rgbycc_out_if.sv @@
// Interface for the YCbCr 4:2:2 result channel.
// Depends on nothing; carries valid, ready and the converted payload.
interface rgbycc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       last_out;

    modport source (
        output valid, luma_first, luma_second, chroma_blue, chroma_red, last_out,
        input  ready
    );

    modport sink (
        input  valid, luma_first, luma_second, chroma_blue, chroma_red, last_out,
        output ready
    );
endinterface

@@ rtl/rgbycc_lane.sv @@
// One pixel lane: the nine rounded coefficient products of one RGB pixel.
// Depends on rgbycc_pkg; the products are registered when load is high.
module rgbycc_lane
    import rgbycc_pkg::*;
(
    input  logic   clk,
    input  logic   load,
    input  pixel_t pixel,
    output prod_t  prod
);

    prod_t prod_reg;
    prod_t prod_next;

    // Rounded product floor((c * k + 128) / 256), kept modulo 2^16.
    function automatic logic [SUM_W-1:0] mul_round(
        input logic [CHAN_W-1:0]        c,
        input logic signed [COEF_W-1:0] k
    );
        logic signed [CHAN_W+COEF_W:0] full;
        logic signed [CHAN_W+COEF_W:0] rnd;
        logic signed [CHAN_W+COEF_W:0] shr;
        full = (CHAN_W + COEF_W + 1)'($signed({1'b0, c})) * (CHAN_W + COEF_W + 1)'(k);
        rnd  = full + 23'sd128;
        shr  = rnd >>> 8;
        return shr[SUM_W-1:0];
    endfunction

    always_comb
    begin
        prod_next.y_r  = mul_round(pixel.red,   COEF_Y_R);
        prod_next.y_g  = mul_round(pixel.green, COEF_Y_G);
        prod_next.y_b  = mul_round(pixel.blue,  COEF_Y_B);
        prod_next.cb_r = mul_round(pixel.red,   COEF_CB_R);
        prod_next.cb_g = mul_round(pixel.green, COEF_CB_G);
        prod_next.cb_b = mul_round(pixel.blue,  COEF_CB_B);
        prod_next.cr_r = mul_round(pixel.red,   COEF_CR_R);
        prod_next.cr_g = mul_round(pixel.green, COEF_CR_G);
        prod_next.cr_b = mul_round(pixel.blue,  COEF_CR_B);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

@@ rtl/rgbycc_merge.sv @@
// Merge stage: sums the lane products, averages chroma over the pair and clamps.
// Depends on rgbycc_pkg; the result is registered when load is high.
module rgbycc_merge
    import rgbycc_pkg::*;
(
    input  logic  clk,
    input  logic  load,
    input  prod_t prod_first,
    input  prod_t prod_second,
    input  logic  last_pair,
    output ycc_t  result
);

    ycc_t result_reg;
    ycc_t result_next;

    logic [SUM_W-1:0] y0_sum;
    logic [SUM_W-1:0] y1_sum;
    logic [SUM_W-1:0] cb_sum;
    logic [SUM_W-1:0] cr_sum;

    // A negative lane gives zero; above 255 after the shift gives 255.
    function automatic logic [CHAN_W-1:0] pack_lane(input logic [SUM_W-1:0] lane);
        logic [CHAN_W-1:0] packed_val;
        if (lane[SUM_W-1])
        begin
            packed_val = '0;
        end
        else if (|lane[SUM_W-2:CHAN_W+5])
        begin
            packed_val = '1;
        end
        else
        begin
            packed_val = lane[CHAN_W+4:5];
        end
        return packed_val;
    endfunction

    always_comb
    begin
        y0_sum = OFFSET_Y + prod_first.y_r + prod_first.y_g + prod_first.y_b;
        y1_sum = OFFSET_Y + prod_second.y_r + prod_second.y_g + prod_second.y_b;
        cb_sum = OFFSET_C + prod_first.cb_r + prod_first.cb_g + prod_first.cb_b
                 + prod_second.cb_r + prod_second.cb_g + prod_second.cb_b;
        cr_sum = OFFSET_C + prod_first.cr_r + prod_first.cr_g + prod_first.cr_b
                 + prod_second.cr_r + prod_second.cr_g + prod_second.cr_b;

        result_next.luma_first  = pack_lane(y0_sum);
        result_next.luma_second = pack_lane(y1_sum);
        result_next.chroma_blue = pack_lane(cb_sum);
        result_next.chroma_red  = pack_lane(cr_sum);
        result_next.last_out    = last_pair;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ rtl/rgb_to_ycbcr_422_pair.sv @@
// Top level of the RGB to YCbCr 4:2:2 pair converter.
// Depends on rgbycc_pkg, rgbycc_in_if, rgbycc_out_if, rgbycc_lane and rgbycc_merge.
//
// Each transaction on pix carries two adjacent RGB pixels and gives one transaction on
// ycc with two luma values and one Cb and one Cr shared by the pair. The block takes a
// new pair every clock cycle while ycc does not stall it; its pipeline holds the two
// pixel lanes, which form all coefficient products in parallel, then the merge stage,
// which sums, averages the chroma over the pair and clamps. The output stage is a
// register, so pix stays ready while a result waits as long as the lane stage is free.
module rgb_to_ycbcr_422_pair
    import rgbycc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rgbycc_in_if.sink    pix,
    rgbycc_out_if.source ycc
);

    logic   s1_valid_reg;
    logic   s1_valid_next;
    logic   s1_last_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_ok;
    logic   s1_load;
    logic   s2_load;
    pixel_t pixel_first;
    pixel_t pixel_second;
    prod_t  prod_first;
    prod_t  prod_second;
    ycc_t   result;

    assign out_ok     = !out_valid_reg || ycc.ready;
    assign pix.ready  = !s1_valid_reg || out_ok;
    assign s1_load    = pix.valid && pix.ready;
    assign s2_load    = s1_valid_reg && out_ok;

    assign pixel_first  = '{red: pix.red_first, green: pix.green_first,
                            blue: pix.blue_first};
    assign pixel_second = '{red: pix.red_second, green: pix.green_second,
                            blue: pix.blue_second};

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (pix.ready)
        begin
            s1_valid_next = pix.valid;
        end
        if (out_ok)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_last_reg <= pix.last_pair;
        end
    end

    rgbycc_lane u_lane_first (
        .clk   (clk),
        .load  (s1_load),
        .pixel (pixel_first),
        .prod  (prod_first)
    );

    rgbycc_lane u_lane_second (
        .clk   (clk),
        .load  (s1_load),
        .pixel (pixel_second),
        .prod  (prod_second)
    );

    rgbycc_merge u_merge (
        .clk         (clk),
        .load        (s2_load),
        .prod_first  (prod_first),
        .prod_second (prod_second),
        .last_pair   (s1_last_reg),
        .result      (result)
    );

    assign ycc.valid       = out_valid_reg;
    assign ycc.luma_first  = result.luma_first;
    assign ycc.luma_second = result.luma_second;
    assign ycc.chroma_blue = result.chroma_blue;
    assign ycc.chroma_red  = result.chroma_red;
    assign ycc.last_out    = result.last_out;

`ifndef SYNTHESIS
    a_accept_fills_lanes: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_load |=> s1_valid_reg
    ) else $error("Accepted transaction did not reach the lane stage.");

    a_lane_holds_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && ycc.valid && !ycc.ready) |=> (s1_valid_reg && $stable(s1_last_reg))
    ) else $error("Lane stage lost or changed a transaction while the output stalled.");

    a_merge_moves_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        s2_load |=> (ycc.valid && ycc.last_out == $past(s1_last_reg))
    ) else $error("Merge stage did not forward the transaction with its last flag.");
`endif

endmodule

@@ tb/rgb_to_ycbcr_422_pair_checker.sv @@
`timescale 1ns / 100ps
// Checker for the RGB to YCbCr 4:2:2 pair converter: predicts each ycc transaction
// from the accepted pix transactions and compares every field in order.
// Depends on rgbycc_pkg, rgbycc_in_if and rgbycc_out_if.
module rgb_to_ycbcr_422_pair_checker
    import rgbycc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    rgbycc_in_if  pix,
    rgbycc_out_if ycc,
    output int    mismatches,
    output int    outstanding
);

    localparam int REPORT_LIMIT = 10;

    ycc_t pending_ycc[$];

    function automatic logic [SUM_W-1:0] rounded_product(logic [CHAN_W-1:0] channel,
                                                         logic signed [COEF_W-1:0] coef);
        int full;
        full = int'(channel) * int'(coef) + 128;
        return SUM_W'(full >>> 8);
    endfunction

    function automatic logic [SUM_W-1:0] weighted_sum(pixel_t px,
                                                      logic signed [COEF_W-1:0] coef_r,
                                                      logic signed [COEF_W-1:0] coef_g,
                                                      logic signed [COEF_W-1:0] coef_b);
        return rounded_product(px.red, coef_r) + rounded_product(px.green, coef_g)
             + rounded_product(px.blue, coef_b);
    endfunction

    function automatic logic [CHAN_W-1:0] clamp_lane(logic [SUM_W-1:0] lane);
        logic [SUM_W-1:0] scaled;
        if (lane[SUM_W-1])
            return '0;
        scaled = lane >> 5;
        return (scaled > 16'd255) ? 8'd255 : scaled[CHAN_W-1:0];
    endfunction

    function automatic ycc_t convert_pair(pixel_t even_px, pixel_t odd_px, logic last);
        logic [SUM_W-1:0] luma_even;
        logic [SUM_W-1:0] luma_odd;
        logic [SUM_W-1:0] blue_diff;
        logic [SUM_W-1:0] red_diff;
        ycc_t result;
        luma_even = OFFSET_Y + weighted_sum(even_px, COEF_Y_R, COEF_Y_G, COEF_Y_B);
        luma_odd  = OFFSET_Y + weighted_sum(odd_px, COEF_Y_R, COEF_Y_G, COEF_Y_B);
        blue_diff = OFFSET_C + weighted_sum(even_px, COEF_CB_R, COEF_CB_G, COEF_CB_B)
                  + weighted_sum(odd_px, COEF_CB_R, COEF_CB_G, COEF_CB_B);
        red_diff  = OFFSET_C + weighted_sum(even_px, COEF_CR_R, COEF_CR_G, COEF_CR_B)
                  + weighted_sum(odd_px, COEF_CR_R, COEF_CR_G, COEF_CR_B);
        result.luma_first  = clamp_lane(luma_even);
        result.luma_second = clamp_lane(luma_odd);
        result.chroma_blue = clamp_lane(blue_diff);
        result.chroma_red  = clamp_lane(red_diff);
        result.last_out    = last;
        return result;
    endfunction

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        ycc_t expected;
        ycc_t observed;
        if (rst_n)
        begin
            if (ycc.valid && ycc.ready)
            begin
                observed = '{ycc.luma_first, ycc.luma_second, ycc.chroma_blue,
                             ycc.chroma_red, ycc.last_out};
                if (pending_ycc.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected ycc transaction: Y %0d/%0d Cb %0d Cr %0d last %0b",
                                 $realtime, observed.luma_first, observed.luma_second,
                                 observed.chroma_blue, observed.chroma_red, observed.last_out);
                end
                else
                begin
                    expected = pending_ycc.pop_front();
                    if (observed.luma_first !== expected.luma_first
                        || observed.luma_second !== expected.luma_second
                        || observed.chroma_blue !== expected.chroma_blue
                        || observed.chroma_red !== expected.chroma_red
                        || observed.last_out !== expected.last_out)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: ycc mismatch: expected Y %0d/%0d Cb %0d Cr %0d last %0b,",
                                      " got Y %0d/%0d Cb %0d Cr %0d last %0b"},
                                     $realtime, expected.luma_first, expected.luma_second,
                                     expected.chroma_blue, expected.chroma_red, expected.last_out,
                                     observed.luma_first, observed.luma_second,
                                     observed.chroma_blue, observed.chroma_red, observed.last_out);
                    end
                end
            end
            if (pix.valid && pix.ready)
                pending_ycc.push_back(convert_pair(
                    '{pix.red_first, pix.green_first, pix.blue_first},
                    '{pix.red_second, pix.green_second, pix.blue_second},
                    pix.last_pair));
            outstanding = pending_ycc.size();
        end
    end

endmodule

@@ tb/rgb_to_ycbcr_422_pair_test.sv @@
`timescale 1ns / 100ps
// Top of the testbench for the RGB to YCbCr 4:2:2 pair converter: drives pixel pairs and
// random back-pressure, and gives the verdict from the checker's counts.
// Depends on rgbycc_pkg, both channel interfaces, the block and the checker.
module rgb_to_ycbcr_422_pair_test
    import rgbycc_pkg::*;
();

    localparam int RANDOM_PAIRS   = 1730;
    localparam int MAX_WAIT       = 17;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   sender_calm = 0;
    int   receiver_calm = 0;
    int   stalled_cycles = 0;

    rgbycc_in_if  pix_if ();
    rgbycc_out_if ycc_if ();

    rgb_to_ycbcr_422_pair dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_if.sink),
        .ycc   (ycc_if.source)
    );

    rgb_to_ycbcr_422_pair_checker ycc_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix         (pix_if),
        .ycc         (ycc_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (ycc_if.valid && ycc_if.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_wait(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(10, 50);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic pixel_t rgb(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        return '{red, green, blue};
    endfunction

    function automatic pixel_t random_pixel();
        logic [7:0] corners[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
        logic [7:0] grey;
        case ($urandom_range(0, 9))
            0, 1:
                return rgb(corners[2'($urandom_range(0, 3))],
                           corners[2'($urandom_range(0, 3))],
                           corners[2'($urandom_range(0, 3))]);
            2:
            begin
                grey = 8'($urandom_range(0, 255));
                return rgb(grey, grey, grey);
            end
            default:
                return rgb(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_pair(pixel_t even_px, pixel_t odd_px, logic last);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0)
        begin
            pix_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_if.valid        = 1'b1;
        pix_if.red_first    = even_px.red;
        pix_if.green_first  = even_px.green;
        pix_if.blue_first   = even_px.blue;
        pix_if.red_second   = odd_px.red;
        pix_if.green_second = odd_px.green;
        pix_if.blue_second  = odd_px.blue;
        pix_if.last_pair    = last;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_ycc();
        int stall;
        forever
        begin
            stall = draw_wait(receiver_calm);
            if (stall > 0)
            begin
                ycc_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            ycc_if.ready = 1'b1;
            @(posedge clk);
            while (!ycc_if.valid)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    initial
    begin
        pixel_t black;
        pixel_t white;
        black = rgb(8'd0, 8'd0, 8'd0);
        white = rgb(8'd255, 8'd255, 8'd255);
        rst_n               = 1'b0;
        pix_if.valid        = 1'b0;
        pix_if.red_first    = '0;
        pix_if.green_first  = '0;
        pix_if.blue_first   = '0;
        pix_if.red_second   = '0;
        pix_if.green_second = '0;
        pix_if.blue_second  = '0;
        pix_if.last_pair    = 1'b0;
        ycc_if.ready        = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        fork
            drain_ycc();
        join_none

        send_pair(black, black, 1'b0);
        send_pair(white, white, 1'b1);
        send_pair(black, white, 1'b0);
        send_pair(white, black, 1'b1);
        send_pair(rgb(8'd255, 8'd0, 8'd0), rgb(8'd255, 8'd0, 8'd0), 1'b0);
        send_pair(rgb(8'd0, 8'd255, 8'd0), rgb(8'd0, 8'd255, 8'd0), 1'b0);
        send_pair(rgb(8'd0, 8'd0, 8'd255), rgb(8'd0, 8'd0, 8'd255), 1'b0);
        send_pair(rgb(8'd255, 8'd255, 8'd0), rgb(8'd255, 8'd255, 8'd0), 1'b0);
        send_pair(rgb(8'd0, 8'd255, 8'd255), rgb(8'd0, 8'd255, 8'd255), 1'b0);
        send_pair(rgb(8'd255, 8'd0, 8'd255), rgb(8'd255, 8'd0, 8'd255), 1'b1);
        send_pair(rgb(8'd1, 8'd1, 8'd1), rgb(8'd254, 8'd254, 8'd254), 1'b0);
        send_pair(rgb(8'd128, 8'd128, 8'd128), rgb(8'd127, 8'd127, 8'd127), 1'b0);
        send_pair(rgb(8'd255, 8'd0, 8'd0), rgb(8'd0, 8'd0, 8'd255), 1'b0);
        send_pair(rgb(8'd0, 8'd0, 8'd255), rgb(8'd255, 8'd255, 8'd0), 1'b0);
        send_pair(rgb(8'd85, 8'd170, 8'd85), rgb(8'd170, 8'd85, 8'd170), 1'b1);
        send_pair(rgb(8'd16, 8'd235, 8'd16), rgb(8'd235, 8'd16, 8'd235), 1'b0);

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i % 600 == 300)
            begin
                pix_if.valid = 1'b0;
                while (outstanding != 0)
                    @(negedge clk);
            end
            send_pair(random_pixel(), random_pixel(), $urandom_range(0, 7) == 0);
        end

        pix_if.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
